// ----- rtl/ilid_pkg.sv -----
package ilid_pkg;

    // Field widths of one input beat and one result beat
    localparam int ACT_W = 3;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int CNT_W = 7;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_GET      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_AT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_AT   = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Value returned when nothing is read
    localparam logic [VAL_W-1:0] NOT_FOUND = '1;

    typedef logic signed [VAL_W-1:0] t_value;

endpackage

// ----- rtl/ilid_cell_ram.sv -----
module ilid_cell_ram
    import ilid_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_value        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_value        o_rdata
);

    t_value r_mem [DEPTH];
    t_value r_rdata;

    // Write one cell per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/indexed_list_insert_delete_unit.sv -----
// Indexed list: an ordered sequence of up to CAPACITY signed 32-bit values
// held in a single-port-write, single-port-read cell memory.
// Command channel: a beat (i_action, i_position, i_value) is taken at a rising
// edge with start high and busy low. busy stays high while the action runs.
// Result channel: o_done is high for exactly one cycle with o_read_value,
// o_status and o_count; the receiver cannot stall it and must take it then.
// Steps of each action after the accepting edge:
//   get in range            one registered memory read (S_GET)
//   insert at index k       shift the cells from k to the tail up, then write at k
//   delete at index k       shift the cells above k down one place
//   ignored or rejected     result straight from idle, no memory work
// Each element moved passes through a read state and a write state, using the one
// memory port pair and the shared index step unit; that sets the rate.
// A new beat may be taken at the edge that ends the result cycle.
// Reset empties the sequence at once; the cell memory is not cleared, since
// only cells below the count are ever read.
module indexed_list_insert_delete_unit
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [ACT_W-1:0] i_action,
    input  logic [POS_W-1:0] i_position,
    input  t_value           i_value,
    output logic             o_done,
    output t_value           o_read_value,
    output logic [ST_W-1:0]  o_status,
    output logic [CNT_W-1:0] o_count
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int UW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (UW > POS_W) ? UW : POS_W;

    localparam logic [UW-1:0] CAP_U = UW'(CAPACITY);
    localparam logic [UW-1:0] ONE_U = UW'(1);

    // Sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_INSW = 3'd2;
    localparam logic [2:0] S_DEL  = 3'd3;
    localparam logic [2:0] S_DELW = 3'd4;
    localparam logic [2:0] S_GET  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [UW-1:0]    r_used,  n_used;
    logic [UW-1:0]    r_k,     n_k;
    logic [UW-1:0]    r_at,    n_at;
    t_value           r_ins_val, n_ins_val;
    logic             r_done,  n_done;
    t_value           r_rd_val, n_rd_val;
    logic [ST_W-1:0]  r_status, n_status;
    logic [CNT_W-1:0] r_count,  n_count;

    logic             w_down;
    logic [UW-1:0]    w_k_adj;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    t_value           w_wdata;
    logic [AW-1:0]    w_raddr;
    t_value           w_rdata;
    logic [CMP_W-1:0] w_pos_c;
    logic [CMP_W-1:0] w_used_c;
    logic [UW-1:0]    w_ins_at;
    logic             w_ins_range;

    ilid_cell_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Shared index step: down for insert, up for delete
    assign w_down  = (r_state == S_INS) || (r_state == S_INSW);
    assign w_k_adj = w_down ? (r_k - ONE_U) : (r_k + ONE_U);

    assign w_pos_c  = CMP_W'(i_position);
    assign w_used_c = CMP_W'(r_used);

    // Insert target and its range check
    always_comb begin
        w_ins_at    = r_used;
        w_ins_range = 1'b0;
        case (i_action)
            ACT_INS_AT: begin
                w_ins_at    = UW'(i_position);
                w_ins_range = (w_pos_c > w_used_c);
            end
            ACT_INS_HEAD: begin
                w_ins_at = '0;
            end
            default: begin
                w_ins_at = r_used;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_k       = r_k;
        n_at      = r_at;
        n_ins_val = r_ins_val;
        n_done    = 1'b0;
        n_rd_val  = r_rd_val;
        n_status  = r_status;
        n_count   = r_count;
        w_we      = 1'b0;
        w_waddr   = r_k[AW-1:0];
        w_wdata   = w_rdata;
        w_raddr   = w_k_adj[AW-1:0];

        case (r_state)
            S_IDLE: begin
                w_raddr = AW'(i_position);
                if (start) begin
                    n_rd_val = NOT_FOUND;
                    n_status = ST_RANGE;
                    n_count  = CNT_W'(r_used);
                    case (i_action)
                        ACT_GET: begin
                            if (w_pos_c < w_used_c) begin
                                n_state = S_GET;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        ACT_INS_AT, ACT_INS_HEAD, ACT_INS_TAIL: begin
                            if (w_ins_range) begin
                                n_done = 1'b1;
                            end else if (r_used >= CAP_U) begin
                                n_status = ST_FULL;
                                n_done   = 1'b1;
                            end else begin
                                n_k       = r_used;
                                n_at      = w_ins_at;
                                n_ins_val = i_value;
                                n_state   = S_INS;
                            end
                        end
                        ACT_DEL_AT: begin
                            if (w_pos_c >= w_used_c) begin
                                n_done = 1'b1;
                            end else begin
                                n_k     = UW'(i_position);
                                n_state = S_DEL;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_GET: begin
                n_rd_val = w_rdata;
                n_status = ST_DONE;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end

            // Move cells up from the tail until the gap reaches the target
            S_INS: begin
                if (r_k > r_at) begin
                    n_state = S_INSW;
                end else begin
                    w_we     = 1'b1;
                    w_waddr  = r_at[AW-1:0];
                    w_wdata  = r_ins_val;
                    n_used   = r_used + ONE_U;
                    n_count  = CNT_W'(r_used + ONE_U);
                    n_status = ST_DONE;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_INSW: begin
                w_we    = 1'b1;
                n_k     = w_k_adj;
                n_state = S_INS;
            end

            // Move cells down over the removed one
            S_DEL: begin
                if (w_k_adj < r_used) begin
                    n_state = S_DELW;
                end else begin
                    n_used   = r_used - ONE_U;
                    n_count  = CNT_W'(r_used - ONE_U);
                    n_status = ST_DONE;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_DELW: begin
                w_we    = 1'b1;
                n_k     = w_k_adj;
                n_state = S_DEL;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_at      <= n_at;
        r_ins_val <= n_ins_val;
        r_rd_val  <= n_rd_val;
        r_status  <= n_status;
        r_count   <= n_count;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_read_value = r_rd_val;
    assign o_status     = r_status;
    assign o_count      = r_count;

endmodule

// ----- bench/indexed_list_insert_delete_unit_tb.sv -----
`timescale 1ns / 100ps

module indexed_list_insert_delete_unit_tb;
    import ilid_pkg::*;

    localparam int CAPACITY      = 64;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 165;

    // One result beat as the block should present it
    typedef struct {
        t_value           read_value;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
    } t_list_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [ACT_W-1:0] i_action;
    logic [POS_W-1:0] i_position;
    t_value           i_value;
    logic             o_done;
    t_value           o_read_value;
    logic [ST_W-1:0]  o_status;
    logic [CNT_W-1:0] o_count;

    // Shadow copy of the sequence and the results still owed by the block
    t_value       list_cells [CAPACITY];
    int           list_used;
    t_list_result owed_results [$];
    int           fail_count;
    int           cycle_count;
    int           sender_idle_pct;

    indexed_list_insert_delete_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_done       (o_done),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one action to the shadow sequence and return the result it owes
    function automatic t_list_result apply_list_action(logic [ACT_W-1:0] act,
                                                       logic [POS_W-1:0] pos,
                                                       t_value val);
        t_list_result res;
        int at;
        int k;
        res.read_value = t_value'(NOT_FOUND);
        res.status     = ST_RANGE;
        at = -1;
        case (act)
            ACT_GET: begin
                if (int'(pos) < list_used) begin
                    res.read_value = list_cells[pos];
                    res.status     = ST_DONE;
                end
            end
            ACT_INS_AT:   at = int'(pos);
            ACT_INS_HEAD: at = 0;
            ACT_INS_TAIL: at = list_used;
            ACT_DEL_AT: begin
                if (int'(pos) < list_used) begin
                    for (k = int'(pos); k + 1 < list_used; k++)
                        list_cells[k] = list_cells[k + 1];
                    list_used--;
                    res.status = ST_DONE;
                end
            end
            default: ;
        endcase
        // Insert: range check first, then the full check, then shift up
        if (at >= 0) begin
            if (at > list_used) begin
                res.status = ST_RANGE;
            end else if (list_used >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                for (k = list_used; k > at; k--)
                    list_cells[k] = list_cells[k - 1];
                list_cells[at] = val;
                list_used++;
                res.status = ST_DONE;
            end
        end
        res.count = CNT_W'(list_used);
        return res;
    endfunction

    // Drive random junk on the command fields while start is low
    task automatic drive_idle_fields();
        i_action   <= ACT_W'($urandom);
        i_position <= POS_W'($urandom);
        i_value    <= t_value'($urandom);
    endtask

    // Send one command beat; returns at the edge that accepts it
    task automatic issue_command(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                 t_value val);
        int gap;
        int i;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(1, ($urandom_range(3) == 0) ? 40 : 4);
        if (gap > 0) begin
            start <= 1'b0;
            drive_idle_fields();
            for (i = 1; i < gap; i++) begin
                @(posedge i_clk);
                drive_idle_fields();
            end
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_action   <= act;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        owed_results.push_back(apply_list_action(act, pos, val));
    endtask

    // Hold the sender off until every owed result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Check each result beat against the oldest owed result
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (owed_results.size() == 0) begin
                $error("unexpected result beat: read_value %0d status %0d count %0d",
                       o_read_value, o_status, o_count);
                fail_count++;
            end else begin
                t_list_result exp_res;
                exp_res = owed_results.pop_front();
                if (o_read_value !== exp_res.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           exp_res.read_value, o_read_value);
                    fail_count++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    fail_count++;
                end
                if (o_count !== exp_res.count) begin
                    $error("count: expected %0d, got %0d", exp_res.count, o_count);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("indexed_list_insert_delete_unit regression: fail");
            $finish;
        end
    end

    // Gets, deletes, an out-of-range insert and the unused action codes against an empty sequence
    task automatic test_empty_list();
        issue_command(ACT_GET, 8'd0, 32'sd0);
        issue_command(ACT_GET, 8'd255, 32'sd0);
        issue_command(ACT_DEL_AT, 8'd0, 32'sd0);
        issue_command(ACT_DEL_AT, 8'd255, 32'sd0);
        issue_command(ACT_INS_AT, 8'd1, 32'sd7);
        issue_command(ACT_W'(5), 8'd0, 32'sd0);
        issue_command(ACT_W'(6), 8'd85, -32'sd1);
        issue_command(ACT_W'(7), 8'd170, 32'sh5555_5555);
    endtask

    // Inserts at head, tail and index, reads and deletes on a short sequence
    task automatic test_basic_edits();
        int i;
        issue_command(ACT_INS_HEAD, 8'd0, 32'sh8000_0000);
        issue_command(ACT_INS_TAIL, 8'd200, 32'sh7fff_ffff);
        issue_command(ACT_INS_AT, 8'd1, -32'sd1);
        issue_command(ACT_INS_AT, 8'd3, 32'sd0);
        issue_command(ACT_INS_AT, 8'd5, 32'sd9);
        for (i = 0; i <= 4; i++)
            issue_command(ACT_GET, POS_W'(i), 32'sd0);
        issue_command(ACT_DEL_AT, 8'd1, 32'sd0);
        issue_command(ACT_DEL_AT, 8'd2, 32'sd0);
        issue_command(ACT_DEL_AT, 8'd5, 32'sd0);
        issue_command(ACT_GET, 8'd0, 32'sd0);
        issue_command(ACT_GET, 8'd1, 32'sd0);
    endtask

    // Fill to capacity, poke at the full sequence, then empty it again
    task automatic test_fill_to_capacity();
        logic [ACT_W-1:0] act;
        while (list_used < CAPACITY) begin
            case ($urandom_range(2))
                0:       act = ACT_INS_HEAD;
                1:       act = ACT_INS_TAIL;
                default: act = ACT_INS_AT;
            endcase
            issue_command(act, POS_W'($urandom_range(list_used)), t_value'($urandom));
        end
        issue_command(ACT_INS_HEAD, 8'd0, 32'sd1);
        issue_command(ACT_INS_TAIL, 8'd0, 32'sd2);
        issue_command(ACT_INS_AT, 8'd0, 32'sd3);
        issue_command(ACT_INS_AT, POS_W'(CAPACITY), 32'sd4);
        issue_command(ACT_INS_AT, POS_W'(CAPACITY + 1), 32'sd5);
        issue_command(ACT_INS_AT, 8'd255, 32'sd6);
        issue_command(ACT_GET, POS_W'(CAPACITY - 1), 32'sd0);
        issue_command(ACT_GET, POS_W'(CAPACITY), 32'sd0);
        issue_command(ACT_GET, 8'd255, 32'sd0);
        issue_command(ACT_DEL_AT, POS_W'(CAPACITY), 32'sd0);
        while (list_used > 0)
            issue_command(ACT_DEL_AT, POS_W'($urandom_range(list_used - 1)), 32'sd0);
    endtask

    // Random edits that swing the length between empty and full
    task automatic test_random_edits(int num_items, int idle_pct);
        logic [ACT_W-1:0] act;
        logic [POS_W-1:0] pos;
        t_value           val;
        bit               grow;
        int               pick;
        int               i;
        sender_idle_pct = idle_pct;
        grow = 1'b1;
        for (i = 0; i < num_items; i++) begin
            // flip direction at the ends, and now and then at random
            if (list_used == CAPACITY && $urandom_range(3) == 0)
                grow = 1'b0;
            else if (list_used == 0 && $urandom_range(3) == 0)
                grow = 1'b1;
            else if ($urandom_range(63) == 0)
                grow = ~grow;
            pick = $urandom_range(99);
            if (pick < 20)
                act = ACT_GET;
            else if (pick < 95) begin
                pick = $urandom_range(99);
                if (grow)
                    act = (pick < 40) ? ACT_INS_AT : (pick < 60) ? ACT_INS_HEAD :
                          (pick < 80) ? ACT_INS_TAIL : ACT_DEL_AT;
                else
                    act = (pick < 10) ? ACT_INS_AT : (pick < 15) ? ACT_INS_HEAD :
                          (pick < 20) ? ACT_INS_TAIL : ACT_DEL_AT;
            end else
                act = ACT_W'($urandom_range(5, 7));
            // mostly in-range positions, some anywhere in the field
            if ($urandom_range(99) < 15)
                pos = POS_W'($urandom);
            else if (act == ACT_INS_AT)
                pos = POS_W'($urandom_range(list_used));
            else
                pos = POS_W'((list_used == 0) ? 0 : $urandom_range(list_used - 1));
            case ($urandom_range(9))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7fff_ffff;
                2:       val = -32'sd1;
                default: val = t_value'($urandom);
            endcase
            issue_command(act, pos, val);
        end
        drain_results();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_action        <= ACT_GET;
        i_position      <= '0;
        i_value         <= '0;
        list_used        = 0;
        fail_count       = 0;
        cycle_count      = 0;
        sender_idle_pct  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_basic_edits();
        drain_results();
        sender_idle_pct = 45;
        test_fill_to_capacity();
        drain_results();
        test_random_edits(PHASE_ITEMS, 0);
        test_random_edits(PHASE_ITEMS, 45);
        test_random_edits(PHASE_ITEMS, 9);

        // Let any stray result beat show up before judging
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (owed_results.size() != 0) begin
            $error("%0d results never arrived", owed_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("indexed_list_insert_delete_unit regression: pass");
        end else begin
            $display("indexed_list_insert_delete_unit regression: fail");
        end
        $finish;
    end

endmodule
